// ===== hdl/clu_pkg.sv =====
package clu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_SCALE_DEF = 8;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 4;
    localparam int SEEN_W  = 2;
    localparam int COEF_W  = 12;

    localparam logic [CFG_W-1:0] SCALE_RST = CFG_W'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF,
        S_TSTEP,
        S_MA,
        S_MU,
        S_MW
    } t_state;

    typedef enum logic [1:0] {
        OP_U,
        OP_W,
        OP_V
    } t_op;

endpackage

// ===== hdl/clu_in_if.sv =====
interface clu_in_if;
    logic                       valid;
    logic                       ready;
    logic [clu_pkg::PIX_W-1:0]  pixel_in;
    logic                       line_end;

    modport source (output valid, pixel_in, line_end, input ready);
    modport sink   (input valid, pixel_in, line_end, output ready);
endinterface

// ===== hdl/clu_out_if.sv =====
interface clu_out_if;
    logic                       valid;
    logic                       ready;
    logic [clu_pkg::PIX_W-1:0]  pixel_out;
    logic                       run_last;
    logic                       line_last;

    modport source (output valid, pixel_out, run_last, line_last, input ready);
    modport sink   (input valid, pixel_out, run_last, line_last, output ready);
endinterface

// ===== hdl/clu_mac.sv =====
module clu_mac #(
    parameter int FRAC_BITS = clu_pkg::FRAC_BITS_DEF
) (
    input  clu_pkg::t_op                        i_op,
    input  logic signed [clu_pkg::COEF_W-1:0]   i_a,
    input  logic signed [clu_pkg::COEF_W-1:0]   i_b,
    input  logic signed [clu_pkg::COEF_W-1:0]   i_c,
    input  logic [clu_pkg::PIX_W-1:0]           i_q1,
    input  logic signed [FRAC_BITS+clu_pkg::COEF_W+1:0] i_u,
    input  logic signed [FRAC_BITS+clu_pkg::COEF_W+2:0] i_w,
    input  logic [FRAC_BITS:0]                  i_t,
    output logic signed [FRAC_BITS+clu_pkg::COEF_W+1:0] o_u,
    output logic signed [FRAC_BITS+clu_pkg::COEF_W+2:0] o_w,
    output logic [clu_pkg::PIX_W-1:0]           o_v
);
    import clu_pkg::*;

    localparam int U_W  = FRAC_BITS + COEF_W + 2;
    localparam int W_W  = U_W + 1;
    localparam int MA_W = W_W;
    localparam int P_W  = MA_W + FRAC_BITS + 2;
    localparam int V_W  = P_W + 1;
    localparam int SH_V = 2 * FRAC_BITS + 1;

    localparam logic signed [P_W-1:0] RND_F  = P_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [V_W-1:0] RND_V  = V_W'(1) <<< (SH_V - 1);
    localparam logic signed [V_W-1:0] SAT_HI = V_W'(255);

    logic signed [MA_W-1:0]       mul_a;
    logic signed [FRAC_BITS+1:0]  mul_b;
    logic signed [P_W-1:0]        prod;
    logic signed [V_W-1:0]        acc;
    logic signed [V_W-1:0]        vs;

    // one shared multiplier, operand picked by the step
    always_comb begin
        mul_b = signed'({1'b0, i_t});
        case (i_op)
            OP_U:    mul_a = MA_W'(i_a);
            OP_W:    mul_a = MA_W'(i_u);
            OP_V:    mul_a = MA_W'(i_w);
            default: mul_a = '0;
        endcase
        prod = mul_a * mul_b;

        o_u = U_W'(prod) + (U_W'(i_b) <<< FRAC_BITS);
        o_w = W_W'((prod + RND_F) >>> FRAC_BITS) + (W_W'(i_c) <<< FRAC_BITS);

        acc = (V_W'(signed'({1'b0, i_q1})) <<< SH_V) + V_W'(prod) + RND_V;
        vs  = acc >>> SH_V;
        if (vs < 0) begin
            o_v = '0;
        end else if (vs > SAT_HI) begin
            o_v = PIX_W'(255);
        end else begin
            o_v = vs[PIX_W-1:0];
        end
    end

endmodule

// ===== hdl/cubic_line_upscaler.sv =====
// channel  | dir | payload                          | transfer when
// i_pix    | in  | pixel_in[7:0], line_end          | valid && ready
// o_res    | out | pixel_out[7:0], run_last, line_last | valid && ready
// i_cfg_*  | in  | scale_factor[3:0]                | i_cfg_we
//
// an item with k intervals (0..2) runs a coefficient step per interval and, for each
// of its S results (S the clamped scale), a t step plus three products through the
// single shared multiplier in clu_mac, so the multiplier sets the rate.
// reset is synchronous: history, sample count and output valid clear, scale
// returns to 2. a held output register stalls the sequencer in its last step.
module cubic_line_upscaler #(
    parameter int FRAC_BITS = clu_pkg::FRAC_BITS_DEF,
    parameter int MAX_SCALE = clu_pkg::MAX_SCALE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [clu_pkg::CFG_W-1:0]   i_cfg_wdata,
    clu_in_if.sink                      i_pix,
    clu_out_if.source                   o_res
);
    import clu_pkg::*;

    localparam int U_W = FRAC_BITS + COEF_W + 2;
    localparam int W_W = U_W + 1;
    localparam int T_W = FRAC_BITS + 1;
    localparam int SW  = $clog2(MAX_SCALE + 1);
    localparam int IW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

    // per-scale step of t: quotient and remainder of 2^F / S
    logic [T_W-1:0] rcp_q [MAX_SCALE];
    logic [SW-1:0]  rcp_r [MAX_SCALE];
    for (genvar g = 0; g < MAX_SCALE; g++) begin : g_rcp
        localparam int DIV = g + 1;
        assign rcp_q[g] = T_W'((64'd1 << FRAC_BITS) / DIV);
        assign rcp_r[g] = SW'((64'd1 << FRAC_BITS) % DIV);
    end

    t_state r_state, n_state;
    t_op    unit_op;

    logic [CFG_W-1:0]         r_cfg;
    logic [PIX_W-1:0]         r_hist [3];
    logic [SEEN_W-1:0]        r_seen;
    logic [PIX_W-1:0]         r_win [5];
    logic [1:0]               r_nint;
    logic                     r_end;
    logic [SW-1:0]            r_s, r_half, r_str, r_tr, r_j;
    logic [T_W-1:0]           r_stq, r_tq;
    logic signed [COEF_W-1:0] r_a, r_b, r_c;
    logic [PIX_W-1:0]         r_q1;
    logic signed [U_W-1:0]    r_u;
    logic signed [W_W-1:0]    r_w;
    logic                     r_out_valid;
    logic [PIX_W-1:0]         r_out_pix;
    logic                     r_out_run, r_out_line;

    logic                     in_xfer, out_free, out_load, last_j, last_int;
    logic                     has0, has1;
    logic [SW-1:0]            s_eff;
    logic [IW-1:0]            s_idx;
    logic [SW:0]              tr_sum;
    logic signed [COEF_W-1:0] q [4];
    logic signed [COEF_W-1:0] coef_a, coef_b, coef_c;
    logic signed [U_W-1:0]    unit_u;
    logic signed [W_W-1:0]    unit_w;
    logic [PIX_W-1:0]         unit_v;

    // no transfer while reset is held
    assign i_pix.ready     = i_rst_n && (r_state == S_IDLE);
    assign in_xfer         = i_pix.valid && i_pix.ready;
    assign out_free        = !r_out_valid || o_res.ready;
    assign last_j          = (r_j == r_s);
    assign last_int        = (r_nint == 2'd1);
    assign out_load        = (r_state == S_MW) && out_free;
    assign has0            = (r_seen >= SEEN_W'(2));
    assign has1            = i_pix.line_end && (r_seen != '0);

    assign o_res.valid     = r_out_valid;
    assign o_res.pixel_out = r_out_pix;
    assign o_res.run_last  = r_out_run;
    assign o_res.line_last = r_out_line;

    always_comb begin
        if (r_cfg == '0) begin
            s_eff = SW'(1);
        end else if (32'(r_cfg) > MAX_SCALE) begin
            s_eff = SW'(MAX_SCALE);
        end else begin
            s_eff = SW'(r_cfg);
        end
        s_idx  = IW'(s_eff - SW'(1));
        tr_sum = {1'b0, r_tr} + {1'b0, r_str};
        for (int k = 0; k < 4; k++) begin
            q[k] = signed'(COEF_W'(r_win[k]));
        end
        coef_a = COEF_W'(q[1] + q[1] + q[1] - q[2] - q[2] - q[2] + q[3] - q[0]);
        coef_b = COEF_W'(q[0] + q[0] + q[2] + q[2] + q[2] + q[2]
                         - q[1] - q[1] - q[1] - q[1] - q[1] - q[3]);
        coef_c = COEF_W'(q[2] - q[0]);
    end

    clu_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_op (unit_op),
        .i_a  (r_a),
        .i_b  (r_b),
        .i_c  (r_c),
        .i_q1 (r_q1),
        .i_u  (r_u),
        .i_w  (r_w),
        .i_t  (r_tq),
        .o_u  (unit_u),
        .o_w  (unit_w),
        .o_v  (unit_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unit_op = OP_V;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (has0 || has1)) begin
                    n_state = S_COEF;
                end
            end
            S_COEF:  n_state = S_TSTEP;
            S_TSTEP: n_state = S_MA;
            S_MA: begin
                unit_op = OP_U;
                n_state = S_MU;
            end
            S_MU: begin
                unit_op = OP_W;
                n_state = S_MW;
            end
            S_MW: begin
                unit_op = OP_V;
                if (out_free) begin
                    if (!last_j) begin
                        n_state = S_TSTEP;
                    end else if (last_int) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_COEF;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= SCALE_RST;
            r_seen      <= '0;
            r_hist[0]   <= '0;
            r_hist[1]   <= '0;
            r_hist[2]   <= '0;
            r_out_valid <= 1'b0;
            r_nint      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (in_xfer) begin
                if (r_seen == '0) begin
                    r_hist[2] <= i_pix.pixel_in;
                    r_hist[1] <= i_pix.pixel_in;
                end else begin
                    r_hist[2] <= r_hist[1];
                    r_hist[1] <= r_hist[0];
                end
                r_hist[0] <= i_pix.pixel_in;
                if (i_pix.line_end) begin
                    r_seen <= '0;
                end else if (r_seen != SEEN_W'(3)) begin
                    r_seen <= r_seen + SEEN_W'(1);
                end
                r_nint <= 2'({1'b0, has0} + {1'b0, has1});
            end else if (out_load && last_j) begin
                r_nint <= r_nint - 2'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (has0) begin
                r_win[0] <= r_hist[2];
                r_win[1] <= r_hist[1];
                r_win[2] <= r_hist[0];
            end else begin
                r_win[0] <= r_hist[1];
                r_win[1] <= r_hist[0];
                r_win[2] <= i_pix.pixel_in;
            end
            r_win[3] <= i_pix.pixel_in;
            r_win[4] <= i_pix.pixel_in;
            r_end    <= i_pix.line_end;
            r_s      <= s_eff;
            r_half   <= s_eff >> 1;
            r_stq    <= rcp_q[s_idx];
            r_str    <= rcp_r[s_idx];
        end
        case (r_state)
            S_COEF: begin
                r_a  <= coef_a;
                r_b  <= coef_b;
                r_c  <= coef_c;
                r_q1 <= r_win[1];
                r_tq <= '0;
                r_tr <= r_half;
                r_j  <= '0;
            end
            S_TSTEP: begin
                // t = round(j * 2^F / S) kept as quotient and remainder
                if (tr_sum >= {1'b0, r_s}) begin
                    r_tr <= SW'(tr_sum - {1'b0, r_s});
                    r_tq <= r_tq + r_stq + T_W'(1);
                end else begin
                    r_tr <= SW'(tr_sum);
                    r_tq <= r_tq + r_stq;
                end
                r_j <= r_j + SW'(1);
            end
            S_MA: r_u <= unit_u;
            S_MU: r_w <= unit_w;
            S_MW: begin
                if (out_free && last_j) begin
                    // next interval reuses the window shifted by one tap
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= r_win[3];
                    r_win[3] <= r_win[4];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_pix  <= unit_v;
            r_out_run  <= last_j && last_int;
            r_out_line <= last_j && last_int && r_end;
        end
    end

    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MA) |-> (r_j != '0) && (r_j <= r_s))
        else $error("sample index out of range");

    a_t_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MA) && (r_j == r_s) |-> (r_tq == T_ONE))
        else $error("t does not reach one at end of interval");

    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MA) |-> (r_tr < r_s))
        else $error("t remainder not below scale");

    a_busy_nint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_nint != '0))
        else $error("sequencer busy with no interval left");

    a_line_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_line |-> r_out_run)
        else $error("line end flag without run end flag");

endmodule

// ===== bench/cubic_line_upscaler_tb.sv =====
`timescale 1ns / 1ps

module cubic_line_upscaler_tb;
    import clu_pkg::*;

    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int MAX_S         = MAX_SCALE_DEF;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SEG_ITEMS     = 25;
    localparam int RANDOM_SCALE  = 16;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             run_last;
        logic             line_last;
    } t_up_result;

    // known_n / known_pix are used when known is set: all results equal known_pix
    typedef struct packed {
        logic             cfg;
        logic [CFG_W-1:0] scale;
        logic [PIX_W-1:0] pix;
        logic             last;
        logic             known;
        logic [4:0]       known_n;
        logic [PIX_W-1:0] known_pix;
    } t_stim_row;

    localparam t_stim_row DIRECTED [21] = '{
        // one-pixel line
        '{1'b0, 4'd0,  8'd255, 1'b1, 1'b1, 5'd0, 8'd0},
        // two-pixel line, only the end interval
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd255, 1'b1, 1'b0, 5'd0, 8'd0},
        // flat white line
        '{1'b0, 4'd0,  8'd255, 1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd255, 1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd255, 1'b1, 1'b1, 5'd4, 8'd255},
        // alternating extremes, overshoot saturates both ways
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd255, 1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b0, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd255, 1'b0, 1'b0, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b1, 1'b0, 5'd0, 8'd0},
        // scale zero acts as one
        '{1'b1, 4'd0,  8'd0,   1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b0, 1'b1, 5'd1, 8'd0},
        '{1'b0, 4'd0,  8'd0,   1'b1, 1'b1, 5'd2, 8'd0},
        // scale above max saturates
        '{1'b1, 4'd15, 8'd17,  1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd200, 1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd3,   1'b0, 1'b0, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd255, 1'b1, 1'b0, 5'd0, 8'd0},
        '{1'b1, 4'd1,  8'd128, 1'b0, 1'b1, 5'd0, 8'd0},
        '{1'b0, 4'd0,  8'd64,  1'b1, 1'b0, 5'd0, 8'd0}
    };

    localparam int SEG_SCALE [9] = '{8, 15, 4, 1, 0, RANDOM_SCALE, 2, 7, RANDOM_SCALE};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    clu_in_if  pix_if ();
    clu_out_if res_if ();

    // side tags travel with the payload so the monitor sees them at the transfer edge
    logic             tag_known;
    logic [4:0]       tag_n;
    logic [PIX_W-1:0] tag_pix;

    int src_idle_pct = 23;
    int snk_idle_pct = 84;
    int hold_asks    = 0;
    int hold_done    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int errors       = 0;

    // predictor state
    logic [CFG_W-1:0] scale_reg;
    logic [PIX_W-1:0] hist [3];
    int               seen_cnt;
    t_up_result       expected_q [$];

    cubic_line_upscaler i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    always #5 clk = ~clk;

    function automatic longint round_shift(input longint x, input int sh);
        return (x + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic [PIX_W-1:0] catmull_point(input int q0, input int q1,
                                                       input int q2, input int q3,
                                                       input longint t);
        longint one, a, b, c, u, w, v;
        one = longint'(1) << FRAC;
        a = longint'(-q0 + 3 * q1 - 3 * q2 + q3);
        b = longint'(2 * q0 - 5 * q1 + 4 * q2 - q3);
        c = longint'(q2 - q0);
        u = b * one + a * t;
        w = round_shift(u * t, FRAC) + c * one;
        v = round_shift(longint'(q1) * one * one * 2 + w * t, 2 * FRAC + 1);
        if (v < 0) return '0;
        if (v > 255) return 8'd255;
        return v[PIX_W-1:0];
    endfunction

    task automatic add_interval(ref logic [PIX_W-1:0] vals [$], input int q0, input int q1,
                                input int q2, input int q3, input int s);
        longint t;
        for (int j = 1; j <= s; j++) begin
            t = ((longint'(j) << FRAC) + longint'(s / 2)) / longint'(s);
            vals.push_back(catmull_point(q0, q1, q2, q3, t));
        end
    endtask

    task automatic predict_item(input logic [PIX_W-1:0] px, input logic last,
                                input logic known, input logic [4:0] known_n,
                                input logic [PIX_W-1:0] known_pix);
        int               s;
        logic [PIX_W-1:0] vals [$];
        t_up_result       r;
        if (scale_reg == '0) s = 1;
        else if (int'(scale_reg) > MAX_S) s = MAX_S;
        else s = int'(scale_reg);
        if (seen_cnt == 0) begin
            hist[0] = px;
            hist[1] = px;
            hist[2] = px;
        end
        if (seen_cnt >= 2) add_interval(vals, hist[2], hist[1], hist[0], px, s);
        if (last && seen_cnt >= 1) add_interval(vals, hist[1], hist[0], px, px, s);
        if (known) begin
            vals.delete();
            repeat (known_n) vals.push_back(known_pix);
        end
        foreach (vals[i]) begin
            r.pixel     = vals[i];
            r.run_last  = (i == vals.size() - 1);
            r.line_last = r.run_last && last;
            expected_q.push_back(r);
        end
        hist[2] = hist[1];
        hist[1] = hist[0];
        hist[0] = px;
        if (last) seen_cnt = 0;
        else if (seen_cnt < 3) seen_cnt++;
    endtask

    // input transfers feed the predictor, output transfers are checked, all on one edge
    always @(posedge clk) begin : res_check
        t_up_result want;
        if (!rst_n) begin
            scale_reg = SCALE_RST;
            hist[0]   = '0;
            hist[1]   = '0;
            hist[2]   = '0;
            seen_cnt  = 0;
        end else begin
            if (cfg_we) scale_reg = cfg_wdata;
            if (pix_if.valid && pix_if.ready)
                predict_item(pix_if.pixel_in, pix_if.line_end, tag_known, tag_n, tag_pix);
            if (res_if.valid && res_if.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d/%0b/%0b",
                             $time, res_if.pixel_out, res_if.run_last, res_if.line_last);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (res_if.pixel_out !== want.pixel || res_if.run_last !== want.run_last
                            || res_if.line_last !== want.line_last) begin
                        $display("%0t: mismatch, expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 $time, want.pixel, want.run_last, want.line_last,
                                 res_if.pixel_out, res_if.run_last, res_if.line_last);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_asks != hold_done) begin
            hold_done    <= hold_asks;
            hold_left    <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic last,
                              input logic known, input logic [4:0] known_n,
                              input logic [PIX_W-1:0] known_pix);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= px;
        pix_if.line_end <= last;
        tag_known       <= known;
        tag_n           <= known_n;
        tag_pix         <= known_pix;
        do @(posedge clk); while (!pix_if.ready);
    endtask

    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        // a pixel with no results may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_scale(input logic [CFG_W-1:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic stream_lines(input int n_items);
        int               sent;
        int               kind;
        int               len;
        int               style;
        int               walk;
        logic [PIX_W-1:0] px;
        logic             last;
        sent = 0;
        walk = $urandom_range(0, 255);
        while (sent < n_items) begin
            kind  = $urandom_range(0, 9);
            style = $urandom_range(0, 2);
            if (kind < 7) len = $urandom_range(3, 12);
            else if (kind < 9) len = $urandom_range(1, 2);
            else len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                case (style)
                    0: px = PIX_W'($urandom_range(0, 255));
                    1: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default: begin
                        walk = walk + $urandom_range(0, 40) - 20;
                        if (walk < 0) walk = 0;
                        if (walk > 255) walk = 255;
                        px = PIX_W'(walk);
                    end
                endcase
                // noise runs drop line ends at random instead of closing the line
                if (kind == 9) last = ($urandom_range(0, 3) == 0);
                else last = (k == len - 1);
                send_pixel(px, last, 1'b0, 5'd0, 8'd0);
                sent++;
            end
        end
    endtask

    initial begin
        int sc;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        pix_if.valid    = 1'b0;
        pix_if.pixel_in = '0;
        pix_if.line_end = 1'b0;
        tag_known       = 1'b0;
        tag_n           = '0;
        tag_pix         = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].cfg) set_scale(DIRECTED[i].scale);
            send_pixel(DIRECTED[i].pix, DIRECTED[i].last, DIRECTED[i].known,
                       DIRECTED[i].known_n, DIRECTED[i].known_pix);
        end

        for (int seg = 0; seg < 9; seg++) begin
            sc = (SEG_SCALE[seg] == RANDOM_SCALE) ? $urandom_range(0, 15) : SEG_SCALE[seg];
            set_scale(CFG_W'(sc));
            if (seg == 3) begin
                src_idle_pct = 84;
                snk_idle_pct = 23;
            end else if (seg == 6) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
                hold_asks++;
            end
            stream_lines(SEG_ITEMS);
        end

        wait_drained();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/clu_pkg.sv
hdl/clu_in_if.sv
hdl/clu_out_if.sv
hdl/clu_mac.sv
hdl/cubic_line_upscaler.sv
bench/cubic_line_upscaler_tb.sv
